// File: design/rldm_pkg.sv
package rldm_pkg;

    localparam int COORD_W = 16;
    localparam int COEF_W  = 16;
    localparam int OUT_W   = 17;
    localparam int DIFF_W  = 17;
    localparam int R2_W    = 18;
    localparam int R4_W    = 36;
    localparam int ZD_W    = 34;
    localparam int CFG_N   = 8;
    localparam int CFG_IW  = $clog2(CFG_N);

    localparam logic [CFG_IW-1:0] CFG_K1_RED   = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] CFG_K1_GREEN = CFG_IW'(1);
    localparam logic [CFG_IW-1:0] CFG_K1_BLUE  = CFG_IW'(2);
    localparam logic [CFG_IW-1:0] CFG_K2_RED   = CFG_IW'(3);
    localparam logic [CFG_IW-1:0] CFG_K2_GREEN = CFG_IW'(4);
    localparam logic [CFG_IW-1:0] CFG_K2_BLUE  = CFG_IW'(5);
    localparam logic [CFG_IW-1:0] CFG_ZOOM_W   = CFG_IW'(6);
    localparam logic [CFG_IW-1:0] CFG_ZOOM_H   = CFG_IW'(7);

    localparam logic [COEF_W-1:0] CFG_RESET = 16'd4096;

    // load enables of the per-channel stages
    typedef struct packed {
        logic s4;
        logic s5;
        logic s6;
        logic s7;
        logic s8;
    } t_chan_en;

endpackage

// File: design/rldm_chan.sv
module rldm_chan (
    input  logic                                     i_clk,
    input  rldm_pkg::t_chan_en                       i_en,
    input  logic signed [rldm_pkg::COEF_W-1:0]       i_k1,
    input  logic signed [rldm_pkg::COEF_W-1:0]       i_k2,
    input  logic        [rldm_pkg::R2_W-1:0]         i_r2q,
    input  logic        [rldm_pkg::R4_W-1:0]         i_r4,
    input  logic signed [rldm_pkg::ZD_W-1:0]         i_zdu,
    input  logic signed [rldm_pkg::ZD_W-1:0]         i_zdv,
    output logic signed [rldm_pkg::OUT_W-1:0]        o_x,
    output logic signed [rldm_pkg::OUT_W-1:0]        o_y
);
    import rldm_pkg::*;

    localparam int K1R2_W = COEF_W + R2_W + 1;
    localparam int HALF_W = COEF_W + R4_W / 2 + 1;
    localparam int K2R4_W = COEF_W + R4_W + 1;
    localparam int F27_W  = 38;
    localparam int FQ_W   = F27_W - 12;
    localparam int PX_W   = ZD_W + FQ_W;
    localparam int RS_W   = PX_W - 27 + 1;

    logic signed [K1R2_W-1:0] r_k1r2_a, n_k1r2_a;
    logic signed [K1R2_W-1:0] r_k1r2_b;
    logic signed [HALF_W-1:0] r_k2lo, n_k2lo;
    logic signed [HALF_W-1:0] r_k2hi, n_k2hi;
    logic signed [FQ_W-1:0]   r_fq, n_fq;
    logic signed [PX_W-1:0]   r_px, n_px;
    logic signed [PX_W-1:0]   r_py, n_py;
    logic signed [OUT_W-1:0]  r_x, n_x;
    logic signed [OUT_W-1:0]  r_y, n_y;

    logic signed [K2R4_W-1:0] w_k2r4;
    logic signed [F27_W-1:0]  w_f27;

    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [PX_W-1:0] p);
        logic signed [PX_W-1:0] t;
        logic signed [RS_W-1:0] s;
        t = p + PX_W'(64'sd67108864);
        s = RS_W'(signed'(t[PX_W-1:27])) + RS_W'(64'sd16384);
        if (s < RS_W'(-64'sd65536)) begin
            return OUT_W'(-64'sd65536);
        end else if (s > RS_W'(64'sd65535)) begin
            return OUT_W'(64'sd65535);
        end else begin
            return s[OUT_W-1:0];
        end
    endfunction

    always_comb begin
        n_k1r2_a = K1R2_W'(i_k1) * K1R2_W'(signed'({1'b0, i_r2q}));
        n_k2lo   = HALF_W'(i_k2) * HALF_W'(signed'({1'b0, i_r4[R4_W/2-1:0]}));
        n_k2hi   = HALF_W'(i_k2) * HALF_W'(signed'({1'b0, i_r4[R4_W-1:R4_W/2]}));
        w_k2r4   = signed'({r_k2hi, {(R4_W/2){1'b0}}}) + K2R4_W'(r_k2lo);
        w_f27    = F27_W'(64'sd134217728) + F27_W'(r_k1r2_b)
                 + signed'(w_k2r4[K2R4_W-1:15]);
        n_fq     = signed'(w_f27[F27_W-1:12]);
        n_px     = PX_W'(i_zdu) * PX_W'(r_fq);
        n_py     = PX_W'(i_zdv) * PX_W'(r_fq);
        n_x      = round_sat(r_px);
        n_y      = round_sat(r_py);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_k1r2_a <= n_k1r2_a;
        end
        if (i_en.s5) begin
            r_k1r2_b <= r_k1r2_a;
            r_k2lo   <= n_k2lo;
            r_k2hi   <= n_k2hi;
        end
        if (i_en.s6) begin
            r_fq <= n_fq;
        end
        if (i_en.s7) begin
            r_px <= n_px;
            r_py <= n_py;
        end
        if (i_en.s8) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

// File: design/radial_lens_distortion_map.sv
// channel   direction  handshake                        payload
// coord     in         i_coord_valid / o_coord_ready    i_coord_u, i_coord_v
// map       out        o_map_valid / i_map_ready        o_{red,green,blue}_{x,y}
// cfg       in         i_cfg_we                         i_cfg_idx, i_cfg_wdata
//
// eight register stages, one beat accepted per cycle unless a full pipe is held by a stalled output
// depth set by the multiplier chain: square, scale, r^4, k2 product, final product
// synchronous active-low reset clears stage valid bits and loads 1.0 into all configuration registers
// a stalled output holds its beat; bubbles in the pipe still close up under a stall
module radial_lens_distortion_map (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_coord_valid,
    output logic                                   o_coord_ready,
    input  logic        [rldm_pkg::COORD_W-1:0]    i_coord_u,
    input  logic        [rldm_pkg::COORD_W-1:0]    i_coord_v,
    output logic                                   o_map_valid,
    input  logic                                   i_map_ready,
    output logic signed [rldm_pkg::OUT_W-1:0]      o_red_x,
    output logic signed [rldm_pkg::OUT_W-1:0]      o_red_y,
    output logic signed [rldm_pkg::OUT_W-1:0]      o_green_x,
    output logic signed [rldm_pkg::OUT_W-1:0]      o_green_y,
    output logic signed [rldm_pkg::OUT_W-1:0]      o_blue_x,
    output logic signed [rldm_pkg::OUT_W-1:0]      o_blue_y,
    input  logic                                   i_cfg_we,
    input  logic        [rldm_pkg::CFG_IW-1:0]     i_cfg_idx,
    input  logic        [rldm_pkg::COEF_W-1:0]     i_cfg_wdata
);
    import rldm_pkg::*;

    localparam int NSTG = 8;

    logic [COEF_W-1:0] r_cfg [CFG_N];

    logic [NSTG:1] r_vld, n_vld;
    logic [NSTG:1] w_en;

    logic signed [DIFF_W-1:0] r_du1, n_du1, r_dv1, n_dv1;
    logic signed [DIFF_W-1:0] r_du2, r_dv2;
    logic        [31:0]       r_squ, n_squ, r_sqv, n_sqv;
    logic signed [2*DIFF_W-1:0] w_squ, w_sqv;
    logic        [32:0]       w_r2sum;
    logic        [R2_W-1:0]   r_r2q, n_r2q;
    logic        [R4_W-1:0]   r_r4, n_r4;
    logic signed [ZD_W-1:0]   r_zdu3, n_zdu3, r_zdv3, n_zdv3;
    logic signed [ZD_W-1:0]   r_zdu4, r_zdv4, r_zdu5, r_zdv5, r_zdu6, r_zdv6;

    t_chan_en w_cen;

    // stage enables ripple back from the output register
    always_comb begin
        w_en[NSTG] = !r_vld[NSTG] || i_map_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld = r_vld;
        if (w_en[1]) begin
            n_vld[1] = i_coord_valid;
        end
        for (int k = 2; k <= NSTG; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_N; i++) begin
                r_cfg[i] <= CFG_RESET;
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_du1   = signed'({1'b0, i_coord_u}) - DIFF_W'(64'sd16384);
        n_dv1   = signed'({1'b0, i_coord_v}) - DIFF_W'(64'sd16384);
        w_squ   = (2*DIFF_W)'(r_du1) * (2*DIFF_W)'(r_du1);
        w_sqv   = (2*DIFF_W)'(r_dv1) * (2*DIFF_W)'(r_dv1);
        n_squ   = w_squ[31:0];
        n_sqv   = w_sqv[31:0];
        w_r2sum = {1'b0, r_squ} + {1'b0, r_sqv};
        n_r2q   = w_r2sum[32:15];
        n_zdu3  = ZD_W'(r_du2) * ZD_W'(signed'({1'b0, r_cfg[CFG_ZOOM_W]}));
        n_zdv3  = ZD_W'(r_dv2) * ZD_W'(signed'({1'b0, r_cfg[CFG_ZOOM_H]}));
        n_r4    = R4_W'(r_r2q) * R4_W'(r_r2q);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_du1 <= n_du1;
            r_dv1 <= n_dv1;
        end
        if (w_en[2]) begin
            r_squ <= n_squ;
            r_sqv <= n_sqv;
            r_du2 <= r_du1;
            r_dv2 <= r_dv1;
        end
        if (w_en[3]) begin
            r_r2q  <= n_r2q;
            r_zdu3 <= n_zdu3;
            r_zdv3 <= n_zdv3;
        end
        if (w_en[4]) begin
            r_r4   <= n_r4;
            r_zdu4 <= r_zdu3;
            r_zdv4 <= r_zdv3;
        end
        if (w_en[5]) begin
            r_zdu5 <= r_zdu4;
            r_zdv5 <= r_zdv4;
        end
        if (w_en[6]) begin
            r_zdu6 <= r_zdu5;
            r_zdv6 <= r_zdv5;
        end
    end

    assign w_cen.s4 = w_en[4];
    assign w_cen.s5 = w_en[5];
    assign w_cen.s6 = w_en[6];
    assign w_cen.s7 = w_en[7];
    assign w_cen.s8 = w_en[8];

    rldm_chan u_red (
        .i_clk (i_clk),
        .i_en  (w_cen),
        .i_k1  (signed'(r_cfg[CFG_K1_RED])),
        .i_k2  (signed'(r_cfg[CFG_K2_RED])),
        .i_r2q (r_r2q),
        .i_r4  (r_r4),
        .i_zdu (r_zdu6),
        .i_zdv (r_zdv6),
        .o_x   (o_red_x),
        .o_y   (o_red_y)
    );

    rldm_chan u_green (
        .i_clk (i_clk),
        .i_en  (w_cen),
        .i_k1  (signed'(r_cfg[CFG_K1_GREEN])),
        .i_k2  (signed'(r_cfg[CFG_K2_GREEN])),
        .i_r2q (r_r2q),
        .i_r4  (r_r4),
        .i_zdu (r_zdu6),
        .i_zdv (r_zdv6),
        .o_x   (o_green_x),
        .o_y   (o_green_y)
    );

    rldm_chan u_blue (
        .i_clk (i_clk),
        .i_en  (w_cen),
        .i_k1  (signed'(r_cfg[CFG_K1_BLUE])),
        .i_k2  (signed'(r_cfg[CFG_K2_BLUE])),
        .i_r2q (r_r2q),
        .i_r4  (r_r4),
        .i_zdu (r_zdu6),
        .i_zdv (r_zdv6),
        .o_x   (o_blue_x),
        .o_y   (o_blue_y)
    );

    assign o_coord_ready = w_en[1];
    assign o_map_valid   = r_vld[NSTG];

    // a free output lets the whole pipe move
    a_ready_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_map_ready |-> o_coord_ready)
        else $error("input stalled while output drains");

    // a held beat in the last inner stage is not dropped
    a_hold_s7: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && !w_en[NSTG]) |=> r_vld[NSTG-1])
        else $error("beat lost in stage seven");

    // no beat comes out straight after reset
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_map_valid)
        else $error("beat out straight after reset");

endmodule

// File: sim/rldm_map_checker.sv
`timescale 1ns / 100ps

module rldm_map_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_coord_valid,
    input  logic                         i_coord_ready,
    input  logic [rldm_pkg::COORD_W-1:0] i_coord_u,
    input  logic [rldm_pkg::COORD_W-1:0] i_coord_v,
    input  logic                         i_map_valid,
    input  logic                         i_map_ready,
    input  logic [rldm_pkg::OUT_W-1:0]   i_red_x,
    input  logic [rldm_pkg::OUT_W-1:0]   i_red_y,
    input  logic [rldm_pkg::OUT_W-1:0]   i_green_x,
    input  logic [rldm_pkg::OUT_W-1:0]   i_green_y,
    input  logic [rldm_pkg::OUT_W-1:0]   i_blue_x,
    input  logic [rldm_pkg::OUT_W-1:0]   i_blue_y,
    input  logic                         i_cfg_we,
    input  logic [rldm_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [rldm_pkg::COEF_W-1:0]  i_cfg_wdata,
    output int                           o_mismatches,
    output int                           o_outstanding,
    output int                           o_checked
);
    import rldm_pkg::*;

    localparam longint HALF_Q15  = 16384;
    localparam longint ONE_Q27   = 64'sd1 <<< 27;
    localparam longint ROUND_Q27 = 64'sd1 <<< 26;
    localparam longint SAT_LO    = -65536;
    localparam longint SAT_HI    = 65535;

    typedef struct packed {
        logic [OUT_W-1:0] red_x;
        logic [OUT_W-1:0] red_y;
        logic [OUT_W-1:0] green_x;
        logic [OUT_W-1:0] green_y;
        logic [OUT_W-1:0] blue_x;
        logic [OUT_W-1:0] blue_y;
    } t_map_beat;

    logic signed [COEF_W-1:0] k1_coef [3];
    logic signed [COEF_W-1:0] k2_coef [3];
    logic        [COEF_W-1:0] zoom_w;
    logic        [COEF_W-1:0] zoom_h;
    t_map_beat                map_expected_q [$];
    int                       mismatches = 0;
    int                       outstanding = 0;
    int                       checked = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;
    assign o_checked     = checked;

    // scale one axis offset by the radial gain and zoom, round half up, recentre, clamp
    function automatic logic [OUT_W-1:0] place_axis(longint offset, longint gain,
                                                    logic [COEF_W-1:0] zoom);
        longint prod;
        longint pos;
        prod = offset * gain * longint'(zoom);
        pos  = ((prod + ROUND_Q27) >>> 27) + HALF_Q15;
        if (pos < SAT_LO) begin
            pos = SAT_LO;
        end else if (pos > SAT_HI) begin
            pos = SAT_HI;
        end
        return pos[OUT_W-1:0];
    endfunction

    function automatic t_map_beat distort_coord(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        longint           du;
        longint           dv;
        longint           r2;
        longint           r4;
        longint           gain;
        logic [OUT_W-1:0] xs [3];
        logic [OUT_W-1:0] ys [3];
        t_map_beat        beat;
        du = longint'(u) - HALF_Q15;
        dv = longint'(v) - HALF_Q15;
        r2 = (du * du + dv * dv) >>> 15;
        r4 = r2 * r2;
        for (int c = 0; c < 3; c++) begin
            gain = (ONE_Q27 + longint'(k1_coef[c]) * r2
                    + ((longint'(k2_coef[c]) * r4) >>> 15)) >>> 12;
            xs[c] = place_axis(du, gain, zoom_w);
            ys[c] = place_axis(dv, gain, zoom_h);
        end
        beat.red_x   = xs[0];
        beat.red_y   = ys[0];
        beat.green_x = xs[1];
        beat.green_y = ys[1];
        beat.blue_x  = xs[2];
        beat.blue_y  = ys[2];
        return beat;
    endfunction

    task automatic check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("map mismatch on %s: expected %0d, got %0d", name,
                         $signed(want), $signed(got));
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_map_beat want;
        if (!i_rst_n) begin
            map_expected_q.delete();
            for (int c = 0; c < 3; c++) begin
                k1_coef[c] = CFG_RESET;
                k2_coef[c] = CFG_RESET;
            end
            zoom_w = CFG_RESET;
            zoom_h = CFG_RESET;
        end else begin
            if (i_map_valid && i_map_ready) begin
                if (map_expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("map beat with nothing expected: red_x %0d red_y %0d",
                                 $signed(i_red_x), $signed(i_red_y));
                    end
                end else begin
                    want = map_expected_q.pop_front();
                    check_field("red_x", want.red_x, i_red_x);
                    check_field("red_y", want.red_y, i_red_y);
                    check_field("green_x", want.green_x, i_green_x);
                    check_field("green_y", want.green_y, i_green_y);
                    check_field("blue_x", want.blue_x, i_blue_x);
                    check_field("blue_y", want.blue_y, i_blue_y);
                    checked++;
                end
            end
            if (i_coord_valid && i_coord_ready) begin
                map_expected_q.push_back(distort_coord(i_coord_u, i_coord_v));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_K1_RED:   k1_coef[0] = i_cfg_wdata;
                    CFG_K1_GREEN: k1_coef[1] = i_cfg_wdata;
                    CFG_K1_BLUE:  k1_coef[2] = i_cfg_wdata;
                    CFG_K2_RED:   k2_coef[0] = i_cfg_wdata;
                    CFG_K2_GREEN: k2_coef[1] = i_cfg_wdata;
                    CFG_K2_BLUE:  k2_coef[2] = i_cfg_wdata;
                    CFG_ZOOM_W:   zoom_w = i_cfg_wdata;
                    CFG_ZOOM_H:   zoom_h = i_cfg_wdata;
                    default: ;
                endcase
            end
        end
        outstanding = map_expected_q.size();
    end

endmodule

// File: sim/radial_lens_distortion_map_tb.sv
`timescale 1ns / 100ps

module radial_lens_distortion_map_tb;
    import rldm_pkg::*;

    localparam int PIPE_DEPTH  = 8;
    localparam int HOLD_CYCLES = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_BEATS = 115;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               coord_valid = 1'b0;
    logic               coord_ready;
    logic [COORD_W-1:0] coord_u = '0;
    logic [COORD_W-1:0] coord_v = '0;
    logic               map_valid;
    logic               map_ready = 1'b0;
    logic [OUT_W-1:0]   red_x;
    logic [OUT_W-1:0]   red_y;
    logic [OUT_W-1:0]   green_x;
    logic [OUT_W-1:0]   green_y;
    logic [OUT_W-1:0]   blue_x;
    logic [OUT_W-1:0]   blue_y;
    logic               cfg_we = 1'b0;
    logic [CFG_IW-1:0]  cfg_idx = '0;
    logic [COEF_W-1:0]  cfg_wdata = '0;

    int mismatches;
    int outstanding;
    int checked;
    int cycles = 0;
    int sent = 0;
    int idle_pct = 12;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    radial_lens_distortion_map uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_coord_valid (coord_valid),
        .o_coord_ready (coord_ready),
        .i_coord_u     (coord_u),
        .i_coord_v     (coord_v),
        .o_map_valid   (map_valid),
        .i_map_ready   (map_ready),
        .o_red_x       (red_x),
        .o_red_y       (red_y),
        .o_green_x     (green_x),
        .o_green_y     (green_y),
        .o_blue_x      (blue_x),
        .o_blue_y      (blue_y),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata)
    );

    rldm_map_checker chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_coord_valid (coord_valid),
        .i_coord_ready (coord_ready),
        .i_coord_u     (coord_u),
        .i_coord_v     (coord_v),
        .i_map_valid   (map_valid),
        .i_map_ready   (map_ready),
        .i_red_x       (red_x),
        .i_red_y       (red_y),
        .i_green_x     (green_x),
        .i_green_y     (green_y),
        .i_blue_x      (blue_x),
        .i_blue_y      (blue_y),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // map receiver: random back-pressure, plus a long hold when asked for
    initial begin
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                map_ready <= 1'b0;
                hold_left--;
            end else if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES - 1;
                map_ready <= 1'b0;
            end else begin
                map_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    task automatic send_coord(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge clk);
            coord_valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        coord_valid <= 1'b1;
        coord_u     <= u;
        coord_v     <= v;
        do @(posedge clk); while (!coord_ready);
        sent++;
    endtask

    // leaves time at a falling edge with the pipe empty
    task automatic drain_maps();
        @(negedge clk);
        coord_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [COEF_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(negedge clk);
    endtask

    task automatic load_coefs(logic [COEF_W-1:0] k1r, logic [COEF_W-1:0] k1g,
                              logic [COEF_W-1:0] k1b, logic [COEF_W-1:0] k2r,
                              logic [COEF_W-1:0] k2g, logic [COEF_W-1:0] k2b,
                              logic [COEF_W-1:0] zw, logic [COEF_W-1:0] zh);
        write_reg(CFG_K1_RED, k1r);
        write_reg(CFG_K1_GREEN, k1g);
        write_reg(CFG_K1_BLUE, k1b);
        write_reg(CFG_K2_RED, k2r);
        write_reg(CFG_K2_GREEN, k2g);
        write_reg(CFG_K2_BLUE, k2b);
        write_reg(CFG_ZOOM_W, zw);
        write_reg(CFG_ZOOM_H, zh);
        cfg_we <= 1'b0;
    endtask

    task automatic send_corners();
        send_coord(16'd0, 16'd0);
        send_coord(16'hFFFF, 16'hFFFF);
        send_coord(16'd32768, 16'd32768);
        send_coord(16'd16384, 16'd16384);
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            return COORD_W'($urandom_range(32768));
        end
        if (pick < 82) begin
            case ($urandom_range(4))
                0: return 16'd0;
                1: return 16'd16383;
                2: return 16'd16384;
                3: return 16'd16385;
                default: return 16'd32768;
            endcase
        end
        return COORD_W'($urandom);
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            return COEF_W'($urandom_range(8192) - 4096);
        end
        if (pick < 75) begin
            return COEF_W'($urandom);
        end
        case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_zoom();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            return COEF_W'($urandom_range(8192, 2048));
        end
        if (pick < 80) begin
            return COEF_W'($urandom);
        end
        case ($urandom_range(2))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return CFG_RESET;
        endcase
    endfunction

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // unity coefficients: centre, edges, corners and codes beyond 1.0
        send_coord(16'd16384, 16'd16384);
        send_coord(16'd0, 16'd0);
        send_coord(16'd32768, 16'd32768);
        send_coord(16'd0, 16'd32768);
        send_coord(16'd32768, 16'd0);
        send_coord(16'd16384, 16'd0);
        send_coord(16'hFFFF, 16'hFFFF);
        send_coord(16'hFFFF, 16'd0);
        send_coord(16'hAAAA, 16'h5555);
        send_coord(16'h5555, 16'hAAAA);
        drain_maps();

        // coefficient and zoom extremes, saturating both ways
        load_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                   16'hFFFF, 16'hFFFF);
        send_corners();
        drain_maps();
        load_coefs(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                   16'hFFFF, 16'hFFFF);
        send_corners();
        drain_maps();
        load_coefs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                   16'h0000, 16'h0000);
        send_corners();
        drain_maps();

        for (int p = 0; p < RAND_PHASES; p++) begin
            load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                       rand_coef(), rand_zoom(), rand_zoom());
            idle_pct = (p == 2) ? 0 : 12;
            if (p == 5) begin
                hold_req++;
            end
            repeat (PHASE_BEATS) send_coord(rand_coord(), rand_coord());
            drain_maps();
        end

        repeat (2 * PIPE_DEPTH) @(negedge clk);
        $display("sent %0d coordinate beats over %0d coefficient sets, with a %0d-cycle map hold",
                 sent, RAND_PHASES + 4, HOLD_CYCLES);
        $display("%0d map beats compared field by field, %0d fields wrong, %0d still owed",
                 checked, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
design/rldm_pkg.sv
design/rldm_chan.sv
design/radial_lens_distortion_map.sv
sim/rldm_map_checker.sv
sim/radial_lens_distortion_map_tb.sv
